// ===== hw/rtl/ray_box_slab_intersect_core_assert.svh =====
// Assertion macros used by the ray-box intersection RTL
`ifndef RAY_BOX_SLAB_INTERSECT_CORE_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_CORE_ASSERT_SVH

// check under reset gating
`define RBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that also holds while reset is asserted
`define RBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/rbs_pkg.sv =====
// Package with constants, codes and types of the ray-box slab intersection core
package rbs_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int BITS_PER_STAGE = 4;
  localparam int NUM_AXES = 3;
  localparam int NUM_REGS = 6;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    FACE_LEFT   = 3'd0,
    FACE_RIGHT  = 3'd1,
    FACE_TOP    = 3'd2,
    FACE_BOTTOM = 3'd3,
    FACE_FRONT  = 3'd4,
    FACE_BACK   = 3'd5
  } face_e;

  typedef struct packed {
    logic [NUM_AXES-1:0] bounded;
    logic                zmiss;
  } side_t;

endpackage

// ===== hw/rtl/rbs_div.sv =====
// Pipelined restoring divider lane: unsigned magnitudes in, signed quotient out
module rbs_div #(
  parameter int QW = 48
) (
  input  logic                 clk_i,
  input  logic                 ce_i,
  input  logic [QW-1:0]        num_i,
  input  logic [31:0]          den_i,
  input  logic                 neg_i,
  output logic signed [QW:0]   quo_o
);
  import rbs_pkg::*;

  localparam int NS = (QW + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int DW = NS * BITS_PER_STAGE;
  localparam int RW = 33;

  logic [RW-1:0] rem_q [NS];
  logic [DW-1:0] sh_q  [NS];
  logic [31:0]   den_q [NS];
  logic          neg_q [NS];
  logic signed [QW:0] quo_q;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [RW-1:0] r_in, r_d;
    logic [DW-1:0] sh_in, sh_d;
    logic [31:0]   den_in;
    logic          neg_in;

    if (s == 0) begin : g_first
      assign r_in   = '0;
      assign sh_in  = DW'(num_i);
      assign den_in = den_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign r_in   = rem_q[s-1];
      assign sh_in  = sh_q[s-1];
      assign den_in = den_q[s-1];
      assign neg_in = neg_q[s-1];
    end

    always_comb begin
      r_d  = r_in;
      sh_d = sh_in;
      for (int k = 0; k < BITS_PER_STAGE; k++) begin
        r_d  = {r_d[RW-2:0], sh_d[DW-1]};
        sh_d = {sh_d[DW-2:0], 1'b0};
        if (r_d >= {1'b0, den_in}) begin
          r_d     = r_d - {1'b0, den_in};
          sh_d[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        rem_q[s] <= r_d;
        sh_q[s]  <= sh_d;
        den_q[s] <= den_in;
        neg_q[s] <= neg_in;
      end
    end
  end

  logic signed [QW:0] mag;
  assign mag = signed'({1'b0, sh_q[NS-1][QW-1:0]});

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      quo_q <= neg_q[NS-1] ? -mag : mag;
    end
  end

  assign quo_o = quo_q;

endmodule

// ===== hw/rtl/ray_box_slab_intersect_core.sv =====
// Top level of the ray versus axis-aligned box slab intersection core
//
// Rays arrive on the s_axis stream, one per transaction, and each ray yields
// exactly one result transaction on m_axis. The box corners sit in six
// registers written over the cfg channel (index 0..5, others ignored);
// write them only while no ray is in flight.
// The six plane divisions run in parallel pipelined restoring dividers
// retiring four quotient bits per stage, so one ray is taken every cycle
// while the output is not stalled.
// Reset clears the box registers to zero and empties the pipeline.
// When m_axis_tready is low with a result waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated. Bubbles advance
// freely while the output register is empty.
// m_axis_tuser carries hit; on a miss distance and face read zero.
module ray_box_slab_intersect_core #(
  parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rbs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [191:0]                  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // entry_distance[31:0], face_code[34:32], zero pad
  output logic [39:0]                   m_axis_tdata,
  // hit
  output logic                          m_axis_tuser
);
  import rbs_pkg::*;

  localparam int QW = 32 + FRAC_BITS;
  localparam int TW = QW + 1;
  localparam int NS = (QW + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int DL = NS + 1;
  localparam logic signed [TW-1:0] T_NONE_LO = {1'b1, {QW{1'b0}}};
  localparam logic signed [TW-1:0] T_NONE_HI = {1'b0, {QW{1'b1}}};
  localparam logic signed [TW-1:0] SAT_HI = TW'(64'sh7FFFFFFF);
  localparam logic signed [TW-1:0] SAT_LO = TW'(-64'sh80000000);

  logic signed [31:0] box_q [NUM_REGS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) box_q[i] <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MIN_X: box_q[0] <= cfg_data_i;
        REG_MIN_Y: box_q[1] <= cfg_data_i;
        REG_MIN_Z: box_q[2] <= cfg_data_i;
        REG_MAX_X: box_q[3] <= cfg_data_i;
        REG_MAX_Y: box_q[4] <= cfg_data_i;
        REG_MAX_Z: box_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic ce;
  logic v1_q;
  logic [DL-1:0] vdiv_q;
  logic vx_q, vy_q, out_valid_q;

  assign ce = !out_valid_q || m_axis_tready;
  assign s_axis_tready = ce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      vdiv_q      <= '0;
      vx_q        <= 1'b0;
      vy_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (ce) begin
      v1_q        <= s_axis_tvalid;
      vdiv_q      <= {vdiv_q[DL-2:0], v1_q};
      vx_q        <= vdiv_q[DL-1];
      vy_q        <= vx_q;
      out_valid_q <= vy_q;
    end
  end

  logic signed [32:0] dlo_q [NUM_AXES];
  logic signed [32:0] dhi_q [NUM_AXES];
  logic signed [31:0] dir_q [NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        dlo_q[a] <= 33'(box_q[a])     - 33'(signed'(s_axis_tdata[32*a +: 32]));
        dhi_q[a] <= 33'(box_q[a + 3]) - 33'(signed'(s_axis_tdata[32*a +: 32]));
        dir_q[a] <= s_axis_tdata[32*(a + 3) +: 32];
      end
    end
  end

  side_t side_d;
  side_t side_q [DL];

  always_comb begin
    side_d.zmiss = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      side_d.bounded[a] = (dir_q[a] != '0);
      if (dir_q[a] == '0 &&
          ((dlo_q[a] > 0 && dhi_q[a] > 0) || (dlo_q[a] < 0 && dhi_q[a] < 0))) begin
        side_d.zmiss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      side_q[0] <= side_d;
      for (int i = 1; i < DL; i++) side_q[i] <= side_q[i-1];
    end
  end

  logic signed [TW-1:0] tlo [NUM_AXES];
  logic signed [TW-1:0] thi [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    logic [31:0] den;
    logic [31:0] mag_lo, mag_hi;
    assign den    = dir_q[a][31] ? 32'(-dir_q[a]) : 32'(dir_q[a]);
    assign mag_lo = dlo_q[a][32] ? 32'(-dlo_q[a]) : 32'(dlo_q[a]);
    assign mag_hi = dhi_q[a][32] ? 32'(-dhi_q[a]) : 32'(dhi_q[a]);

    rbs_div #(.QW(QW)) u_div_lo (
      .clk_i (clk_i),
      .ce_i  (ce),
      .num_i ({mag_lo, {FRAC_BITS{1'b0}}}),
      .den_i (den),
      .neg_i (dlo_q[a][32] ^ dir_q[a][31]),
      .quo_o (tlo[a])
    );

    rbs_div #(.QW(QW)) u_div_hi (
      .clk_i (clk_i),
      .ce_i  (ce),
      .num_i ({mag_hi, {FRAC_BITS{1'b0}}}),
      .den_i (den),
      .neg_i (dhi_q[a][32] ^ dir_q[a][31]),
      .quo_o (thi[a])
    );
  end

  logic signed [TW-1:0] tlo_x_q [NUM_AXES];
  logic signed [TW-1:0] thi_x_q [NUM_AXES];
  logic signed [TW-1:0] ent_x_q [NUM_AXES];
  logic signed [TW-1:0] ext_x_q [NUM_AXES];
  side_t side_x_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      side_x_q <= side_q[DL-1];
      for (int a = 0; a < NUM_AXES; a++) begin
        tlo_x_q[a] <= tlo[a];
        thi_x_q[a] <= thi[a];
        ent_x_q[a] <= (tlo[a] < thi[a]) ? tlo[a] : thi[a];
        ext_x_q[a] <= (tlo[a] < thi[a]) ? thi[a] : tlo[a];
      end
    end
  end

  logic signed [TW-1:0] tmin_d, tmax_d;
  logic signed [TW-1:0] tmin_y_q, tmax_y_q;
  logic signed [TW-1:0] tlo_y_q [NUM_AXES];
  logic signed [TW-1:0] thi_y_q [NUM_AXES];
  side_t side_y_q;

  always_comb begin
    tmin_d = T_NONE_LO;
    tmax_d = T_NONE_HI;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (side_x_q.bounded[a]) begin
        if (ent_x_q[a] > tmin_d) tmin_d = ent_x_q[a];
        if (ext_x_q[a] < tmax_d) tmax_d = ext_x_q[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      tmin_y_q <= tmin_d;
      tmax_y_q <= tmax_d;
      side_y_q <= side_x_q;
      for (int a = 0; a < NUM_AXES; a++) begin
        tlo_y_q[a] <= tlo_x_q[a];
        thi_y_q[a] <= thi_x_q[a];
      end
    end
  end

  logic        hit_d;
  logic [31:0] dist_d;
  face_e       face_d;
  logic        hit_q;
  logic [31:0] dist_q;
  face_e       face_q;

  always_comb begin
    hit_d  = !(side_y_q.zmiss || (tmin_y_q > tmax_y_q));
    dist_d = '0;
    face_d = FACE_LEFT;
    if (hit_d) begin
      if (tmin_y_q > SAT_HI) dist_d = 32'h7FFFFFFF;
      else if (tmin_y_q < SAT_LO) dist_d = 32'h80000000;
      else dist_d = tmin_y_q[31:0];
      if (side_y_q.bounded[0] && tmin_y_q == tlo_y_q[0]) face_d = FACE_LEFT;
      else if (side_y_q.bounded[0] && tmin_y_q == thi_y_q[0]) face_d = FACE_RIGHT;
      else if (side_y_q.bounded[1] && tmin_y_q == thi_y_q[1]) face_d = FACE_TOP;
      else if (side_y_q.bounded[1] && tmin_y_q == tlo_y_q[1]) face_d = FACE_BOTTOM;
      else if (side_y_q.bounded[2] && tmin_y_q == tlo_y_q[2]) face_d = FACE_FRONT;
      else if (side_y_q.bounded[2] && tmin_y_q == thi_y_q[2]) face_d = FACE_BACK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      hit_q  <= hit_d;
      dist_q <= dist_d;
      face_q <= face_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = hit_q;
  assign m_axis_tdata  = {5'b0, face_q, dist_q};

  `include "ray_box_slab_intersect_core_assert.svh"

  `RBS_ASSERT(a_miss_zero, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0, "miss result not zero")
  `RBS_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `RBS_ASSERT(a_face_range, m_axis_tvalid |-> m_axis_tdata[34:32] <= 3'd5, "face code out of range")
  `RBS_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_o, "config channel not ready")

endmodule
